/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, included by cartesian_to_polar_3d_unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every clock edge outside of reset
`define C2P3_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("c2p3 assertion failed");

// property checked on every clock edge, reset included
`define C2P3_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("c2p3 assertion failed");

`else

`define C2P3_ASSERT(lbl, clk, rst_n, prop)
`define C2P3_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hw/rtl/c2p3_pkg.sv */
// ----------------------------------------------------------------------------
// c2p3_pkg
// shared constants, types and the cordic step table in degrees
// ----------------------------------------------------------------------------
package c2p3_pkg;

  localparam int CORDIC_STEPS = 60;
  localparam int CW           = 64;   // cordic datapath width
  localparam int DEG_FRAC     = 52;   // fraction bits of the angle accumulator
  localparam int NORM_TOP     = 59;   // vector magnitude is aligned to this bit
  localparam int RIGHT_DEG    = 90;
  localparam int ANGLE_W      = 24;
  localparam int RANGE_W      = 32;

  // register stages of one angle unit: prepare, one per step, round
  localparam int LATENCY      = CORDIC_STEPS + 2;

  localparam real PI_R        = 3.14159265358979323846;

  // per-step flags that travel along the angle pipeline
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic neg;
  } c2p3_flags_t;

  // atan(2^-i) in degrees with DEG_FRAC fraction bits
  function automatic logic [CW-1:0] step_deg(int i);
    real r;
    r = $atan(2.0 ** (-i)) * 180.0 / PI_R * (2.0 ** DEG_FRAC);
    return CW'(longint'(r));
  endfunction

endpackage

/* hw/rtl/cartesian_to_polar_3d_unit.sv */
// ----------------------------------------------------------------------------
// cartesian_to_polar_3d_unit
// 3d point to horizontal angle, vertical angle and range
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid_i / stall_o  | coord_x_i, coord_y_i, coord_z_i
//  output   | out_valid_o / stall_i | horiz_angle_o, vert_angle_o, range_len_o,
//           |                       | depth_zero_o
//
//  one point per cycle while the result is not stalled; from transfer in to the
//  result showing, each point passes the prepare stage, the 60 steps of the angle
//  cordic and its round stage. the root pipeline is padded to the same length.
//  reset clears only the valid bits; no state survives a point.
//  a stalled result freezes the whole pipeline, so stall_o follows it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_polar_3d_unit #(
  parameter int COORD_BITS      = 24,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int DIST_FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                stall_o,
  input  logic signed [COORD_BITS-1:0]        coord_x_i,
  input  logic signed [COORD_BITS-1:0]        coord_y_i,
  input  logic signed [COORD_BITS-1:0]        coord_z_i,
  output logic                                out_valid_o,
  input  logic                                stall_i,
  output logic signed [c2p3_pkg::ANGLE_W-1:0] horiz_angle_o,
  output logic signed [c2p3_pkg::ANGLE_W-1:0] vert_angle_o,
  output logic        [c2p3_pkg::RANGE_W-1:0] range_len_o,
  output logic                                depth_zero_o
);

  localparam int LAT = c2p3_pkg::LATENCY;
  localparam int AW  = c2p3_pkg::ANGLE_W;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(vld_q[LAT-1] && stall_i);
  assign stall_o     = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [COORD_BITS:0] num_h, num_v;
  logic [AW-1:0]              h_ang, v_ang;
  logic                       h_zero, v_zero;

  assign num_h = (COORD_BITS+1)'(coord_x_i);
  assign num_v = -(COORD_BITS+1)'(coord_y_i);

  c2p3_cordic #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_horiz (
    .clk_i      (clk_i),
    .en_i       (en),
    .num_i      (num_h),
    .den_i      (coord_z_i),
    .angle_o    (h_ang),
    .den_zero_o (h_zero)
  );

  c2p3_cordic #(
    .COORD_BITS      (COORD_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_vert (
    .clk_i      (clk_i),
    .en_i       (en),
    .num_i      (num_v),
    .den_i      (coord_z_i),
    .angle_o    (v_ang),
    .den_zero_o (v_zero)
  );

  c2p3_sqrt #(
    .COORD_BITS     (COORD_BITS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_range (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (coord_x_i),
    .y_i     (coord_y_i),
    .z_i     (coord_z_i),
    .range_o (range_len_o)
  );

  assign horiz_angle_o = $signed(h_ang);
  assign vert_angle_o  = $signed(v_ang);
  assign depth_zero_o  = h_zero;

  // right angle as it appears after output saturation
  localparam longint RIGHT_L = longint'(c2p3_pkg::RIGHT_DEG) <<< ANGLE_FRAC_BITS;
  localparam longint POS_L   = (longint'(1) <<< (AW - 1)) - 1;
  localparam logic [AW-1:0] POS90 = AW'((RIGHT_L > POS_L) ? POS_L : RIGHT_L);
  localparam logic [AW-1:0] NEG90 = AW'(-((RIGHT_L > POS_L + 1) ? POS_L + 1 : RIGHT_L));

  logic h_right, v_right;

  assign h_right = (h_ang == POS90) || (h_ang == NEG90) || (h_ang == '0);
  assign v_right = (v_ang == POS90) || (v_ang == NEG90) || (v_ang == '0);

  `C2P3_ASSERT(a_take_enters, clk_i, rst_ni, in_valid_i && !stall_o |=> vld_q[0])
  `C2P3_ASSERT(a_zero_match, clk_i, rst_ni, out_valid_o |-> h_zero == v_zero)
  `C2P3_ASSERT(a_zero_depth_angle, clk_i, rst_ni, out_valid_o && depth_zero_o |-> h_right && v_right)

endmodule

/* hw/rtl/c2p3_cordic.sv */
// ----------------------------------------------------------------------------
// c2p3_cordic
// pipelined vectoring cordic: atan(num/den) in degrees, one stage per step
// ----------------------------------------------------------------------------
module c2p3_cordic #(
  parameter int COORD_BITS      = 24,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [COORD_BITS:0]        num_i,
  input  logic signed [COORD_BITS-1:0]      den_i,
  output logic        [c2p3_pkg::ANGLE_W-1:0] angle_o,
  output logic                              den_zero_o
);

  localparam int S     = c2p3_pkg::CORDIC_STEPS;
  localparam int W     = c2p3_pkg::CW;
  localparam int AW    = c2p3_pkg::ANGLE_W;
  localparam int ALIGN = c2p3_pkg::NORM_TOP - COORD_BITS;
  localparam int SH    = c2p3_pkg::DEG_FRAC - ANGLE_FRAC_BITS;
  localparam logic [W-1:0] LIM      = W'(c2p3_pkg::RIGHT_DEG) << c2p3_pkg::DEG_FRAC;
  localparam logic [W-1:0] HALF     = W'(1) << (SH - 1);
  localparam logic [W-1:0] RIGHT_Q  = W'(c2p3_pkg::RIGHT_DEG) << ANGLE_FRAC_BITS;
  localparam logic [W-1:0] POS_MAX  = (W'(1) << (AW - 1)) - W'(1);
  localparam logic [W-1:0] NEG_MAX  = W'(1) << (AW - 1);

  logic signed [W-1:0]    x_q   [S+1];
  logic signed [W-1:0]    y_q   [S+1];
  logic signed [W-1:0]    acc_q [S+1];
  c2p3_pkg::c2p3_flags_t  flg_q [S+1];

  logic [W-1:0]           num_mag, den_mag;
  c2p3_pkg::c2p3_flags_t  flg_d;

  always_comb begin
    num_mag = num_i[COORD_BITS] ? W'(-64'(num_i)) : W'(num_i);
    den_mag = den_i[COORD_BITS-1] ? W'(-64'(den_i)) : W'(den_i);
    flg_d.den_zero = (den_i == '0);
    flg_d.num_zero = (num_i == '0);
    if (den_i == '0) begin
      flg_d.neg = num_i[COORD_BITS];
    end else if (num_i == '0) begin
      flg_d.neg = 1'b0;
    end else begin
      flg_d.neg = num_i[COORD_BITS] ^ den_i[COORD_BITS-1];
    end
  end

  // first stage: magnitudes aligned near the top of the datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= $signed(den_mag << ALIGN);
      y_q[0]   <= $signed(num_mag << ALIGN);
      acc_q[0] <= '0;
      flg_q[0] <= flg_d;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_step
    localparam logic signed [W-1:0] STEP = $signed(c2p3_pkg::step_deg(i));
    logic signed [W-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][W-1]) begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          acc_q[i+1] <= acc_q[i] + STEP;
        end else begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          acc_q[i+1] <= acc_q[i] - STEP;
        end
        flg_q[i+1] <= flg_q[i];
      end
    end
  end

  logic [W-1:0]  mag;
  logic [AW-1:0] angle_d;

  always_comb begin
    mag = acc_q[S][W-1] ? '0 : W'(acc_q[S]);
    if (mag > LIM) begin
      mag = LIM;
    end
    mag = (mag + HALF) >> SH;
    if (flg_q[S].den_zero) begin
      mag = flg_q[S].num_zero ? '0 : RIGHT_Q;
    end else if (flg_q[S].num_zero) begin
      mag = '0;
    end
    if (flg_q[S].neg) begin
      if (mag > NEG_MAX) begin
        mag = NEG_MAX;
      end
      angle_d = AW'(-mag);
    end else begin
      if (mag > POS_MAX) begin
        mag = POS_MAX;
      end
      angle_d = AW'(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_o    <= angle_d;
      den_zero_o <= flg_q[S].den_zero;
    end
  end

endmodule

/* hw/rtl/c2p3_sqrt.sv */
// ----------------------------------------------------------------------------
// c2p3_sqrt
// squares, sum and a pipelined restoring square root, one root bit per stage
// ----------------------------------------------------------------------------
module c2p3_sqrt #(
  parameter int COORD_BITS     = 24,
  parameter int DIST_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [COORD_BITS-1:0]       x_i,
  input  logic signed [COORD_BITS-1:0]       y_i,
  input  logic signed [COORD_BITS-1:0]       z_i,
  output logic        [c2p3_pkg::RANGE_W-1:0] range_o
);

  localparam int CB  = COORD_BITS;
  localparam int PW  = 2 * CB;
  localparam int SW  = PW + 2;
  localparam int FS  = 2 * DIST_FRAC_BITS + 2;
  localparam int RW  = SW + FS;
  localparam int NB  = RW / 2;
  localparam int RMW = NB + 3;
  localparam int RGW = c2p3_pkg::RANGE_W;
  localparam int PAD = c2p3_pkg::LATENCY - (NB + 3);

  logic [CB-1:0] ax, ay, az;
  logic [PW-1:0] sqx_q, sqy_q, sqz_q;

  assign ax = x_i[CB-1] ? CB'(-x_i) : CB'(x_i);
  assign ay = y_i[CB-1] ? CB'(-y_i) : CB'(y_i);
  assign az = z_i[CB-1] ? CB'(-z_i) : CB'(z_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= PW'(ax) * PW'(ax);
      sqy_q <= PW'(ay) * PW'(ay);
      sqz_q <= PW'(az) * PW'(az);
    end
  end

  logic [RW-1:0]  rad_q  [NB+1];
  logic [RMW-1:0] rem_q  [NB+1];
  logic [NB-1:0]  root_q [NB+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= RW'(SW'(sqx_q) + SW'(sqy_q) + SW'(sqz_q)) << FS;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_bit
    logic [RMW-1:0] rem_n, trial;
    assign rem_n = {rem_q[k-1][RMW-3:0], rad_q[k-1][RW-1 -: 2]};
    assign trial = RMW'({root_q[k-1], 2'b01});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= rad_q[k-1] << 2;
        if (rem_n >= trial) begin
          rem_q[k]  <= rem_n - trial;
          root_q[k] <= {root_q[k-1][NB-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_n;
          root_q[k] <= {root_q[k-1][NB-2:0], 1'b0};
        end
      end
    end
  end

  // drop the extra root bit with round to nearest, saturate to the output
  logic [NB:0]    rnd;
  logic [63:0]    rnd64;
  logic [RGW-1:0] range_d;
  logic [RGW-1:0] range_q;

  always_comb begin
    rnd     = ({1'b0, root_q[NB]} + (NB+1)'(1)) >> 1;
    rnd64   = 64'(rnd);
    range_d = (rnd64 > 64'hFFFF_FFFF) ? '1 : RGW'(rnd64);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      range_q <= range_d;
    end
  end

  // align with the angle units
  if (PAD > 0) begin : g_pad
    logic [RGW-1:0] pad_q [PAD];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[0] <= range_q;
        for (int p = 1; p < PAD; p++) begin
          pad_q[p] <= pad_q[p-1];
        end
      end
    end
    assign range_o = pad_q[PAD-1];
  end else begin : g_nopad
    assign range_o = range_q;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives 3d points into cartesian_to_polar_3d_unit and checks both angles,
// the range and the zero-depth flag against a cordic / square-root predictor
// ----------------------------------------------------------------------------
module tb;

  localparam int CB       = 24;
  localparam int AFRAC    = 16;
  localparam int DFRAC    = 8;
  localparam int RAD_FRAC = 60;
  localparam int STEPS    = c2p3_pkg::CORDIC_STEPS;
  localparam int DFRAC_A  = c2p3_pkg::DEG_FRAC;
  localparam int ANG_W    = c2p3_pkg::ANGLE_W;
  localparam int TAIL     = c2p3_pkg::LATENCY + 20;

  typedef struct {
    logic [ANG_W-1:0] horiz;
    logic [ANG_W-1:0] vert;
    logic [31:0]      range_len;
    logic             dz;
  } polar_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 stall_o;
  logic signed [CB-1:0] coord_x_i;
  logic signed [CB-1:0] coord_y_i;
  logic signed [CB-1:0] coord_z_i;
  logic                 out_valid_o;
  logic                 stall_i = 1'b0;
  logic signed [ANG_W-1:0] horiz_angle_o;
  logic signed [ANG_W-1:0] vert_angle_o;
  logic [31:0]          range_len_o;
  logic                 depth_zero_o;

  longint unsigned atan_deg_tbl[STEPS];
  polar_t          polar_q[$];
  int              err_cnt;
  bit              stall_quiet;
  int              stall_hold;

  cartesian_to_polar_3d_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .stall_o       (stall_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .out_valid_o   (out_valid_o),
    .stall_i       (stall_i),
    .horiz_angle_o (horiz_angle_o),
    .vert_angle_o  (vert_angle_o),
    .range_len_o   (range_len_o),
    .depth_zero_o  (depth_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // atan(1/m) in radians, taylor series
  function automatic longint unsigned atan_inv(longint unsigned m);
    longint unsigned term, sum, k, p;
    term = (64'd1 << RAD_FRAC) / m;
    sum = 0;
    k = 0;
    while (term != 0) begin
      p = term / (2 * k + 1);
      if (k[0]) sum -= p; else sum += p;
      term /= m * m;
      k++;
    end
    return sum;
  endfunction

  function automatic longint unsigned atan_shift(int i);
    longint unsigned term, sum, k, p;
    term = (64'd1 << RAD_FRAC) >> i;
    sum = 0;
    k = 0;
    while (term != 0) begin
      p = term / (2 * k + 1);
      if (k[0]) sum -= p; else sum += p;
      term = (2 * i < 64) ? (term >> (2 * i)) : 0;
      k++;
    end
    return sum;
  endfunction

  task automatic fill_atan_table();
    longint unsigned qpi, rem, q;
    qpi = 4 * atan_inv(5) - atan_inv(239);
    for (int i = 0; i < STEPS; i++) begin
      rem = (i == 0) ? qpi : atan_shift(i);
      q = rem / qpi;
      rem = rem % qpi;
      for (int b = 0; b < DFRAC_A + 4; b++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= qpi) begin
          rem -= qpi;
          q |= 1;
        end
      end
      atan_deg_tbl[i] = (q * 45) >> 4;
    end
  endtask

  function automatic logic [ANG_W-1:0] angle_deg(longint num, longint den);
    longint unsigned mag, t, u, mx, lim;
    longint x, y, acc, dx, dy;
    int s;
    bit neg;
    if (den == 0) begin
      mag = (num == 0) ? 0 : (64'd90 << AFRAC);
      neg = num < 0;
    end else if (num == 0) begin
      mag = 0;
      neg = 0;
    end else begin
      t = (num < 0) ? -num : num;
      u = (den < 0) ? -den : den;
      mx = (t > u) ? t : u;
      lim = 64'd90 << DFRAC_A;
      s = 0;
      while (mx < (64'd1 << 59)) begin
        mx = mx << 1;
        s++;
      end
      x = u << s;
      y = t << s;
      acc = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; acc += atan_deg_tbl[i];
        end else begin
          x -= dx; y += dy; acc -= atan_deg_tbl[i];
        end
      end
      if (acc < 0) acc = 0;
      mag = acc;
      if (mag > lim) mag = lim;
      mag = (mag + (64'd1 << (DFRAC_A - AFRAC - 1))) >> (DFRAC_A - AFRAC);
      neg = (num < 0) != (den < 0);
    end
    if (neg) begin
      if (mag > (64'd1 << (ANG_W - 1))) mag = 64'd1 << (ANG_W - 1);
      return ANG_W'(0 - mag);
    end
    if (mag > (64'd1 << (ANG_W - 1)) - 1) mag = (64'd1 << (ANG_W - 1)) - 1;
    return ANG_W'(mag);
  endfunction

  function automatic logic [31:0] range_fixed(longint x, longint y, longint z);
    longint unsigned rem, root, bitv, trial;
    rem = x * x + y * y + z * z;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    for (int i = 0; i < DFRAC + 1; i++) begin
      trial = (root << 2) | 1;
      rem = rem << 2;
      root = root << 1;
      if (rem >= trial) begin
        rem -= trial;
        root |= 1;
      end
    end
    root = (root + 1) >> 1;
    if (root > 64'hFFFF_FFFF) root = 64'hFFFF_FFFF;
    return root[31:0];
  endfunction

  function automatic polar_t to_polar(logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                                      logic signed [CB-1:0] cz);
    polar_t r;
    longint x, y, z;
    x = longint'(cx);
    y = longint'(cy);
    z = longint'(cz);
    r.horiz     = angle_deg(x, z);
    r.vert      = angle_deg(-y, z);
    r.range_len = range_fixed(x, y, z);
    r.dz        = (z == 0);
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one point; the transfer happens at the rising edge after a low stall_o
  task automatic send_point(logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                            logic signed [CB-1:0] cz);
    int g;
    bit done;
    in_valid_i <= 1'b1;
    coord_x_i  <= cx;
    coord_y_i  <= cy;
    coord_z_i  <= cz;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if (!stall_o) begin
        polar_q.push_back(to_polar(cx, cy, cz));
        done = 1;
      end
      @(posedge clk_i);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      coord_x_i  <= CB'($urandom);
      coord_y_i  <= CB'($urandom);
      coord_z_i  <= CB'($urandom);
      repeat (g) @(posedge clk_i);
    end
  endtask

  // receiver stalls: mostly short, now and then a long burst, with quiet stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_quiet <= ~stall_quiet;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      stall_i    <= 1'b1;
    end else if (stall_quiet) begin
      stall_i <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      stall_hold <= $urandom_range(10, 40);
      stall_i    <= 1'b1;
    end else begin
      stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  // result is stable between edges; stall_i only moves at the rising edge
  always @(negedge clk_i) begin
    polar_t exp_r;
    int dh, dv;
    if (rst_ni && out_valid_o && !stall_i) begin
      if (polar_q.size() == 0) begin
        $error("result with nothing expected");
        err_cnt++;
      end else begin
        exp_r = polar_q.pop_front();
        dh = int'($signed(horiz_angle_o)) - int'($signed(exp_r.horiz));
        dv = int'($signed(vert_angle_o)) - int'($signed(exp_r.vert));
        // angles may differ by one lsb
        if (dh > 1 || dh < -1) begin
          $error("horiz_angle exp %0d got %0d", $signed(exp_r.horiz), horiz_angle_o);
          err_cnt++;
        end
        if (dv > 1 || dv < -1) begin
          $error("vert_angle exp %0d got %0d", $signed(exp_r.vert), vert_angle_o);
          err_cnt++;
        end
        if (range_len_o !== exp_r.range_len) begin
          $error("range_len exp %0d got %0d", exp_r.range_len, range_len_o);
          err_cnt++;
        end
        if (depth_zero_o !== exp_r.dz) begin
          $error("depth_zero exp %0b got %0b", exp_r.dz, depth_zero_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [CB-1:0] mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    send_point(0, 0, 0);
    send_point(5, -7, 0);
    send_point(-5, 7, 0);
    send_point(0, 3, 0);
    send_point(mn, mn, 0);
    send_point(mx, mx, 0);
    send_point(0, 0, 9);
    send_point(0, 0, -9);
    send_point(1, -1, 1);
    send_point(-1, 1, -1);
    send_point(mx, mx, mx);
    send_point(mn, mn, mn);
    send_point(mx, mn, 1);
    send_point(mn, mx, -1);
    send_point(1, 1, mn);
    send_point(-1, -1, mx);
    send_point(mn, 0, mx);
    send_point(0, mn, mn);
    send_point(3, 4, 12);
    send_point(-1, 0, 1);
  endtask

  task automatic test_random(int n);
    logic signed [CB-1:0] cx, cy, cz;
    int m;
    for (int i = 0; i < n; i++) begin
      cx = CB'($urandom);
      cy = CB'($urandom);
      cz = CB'($urandom);
      case ($urandom_range(0, 9))
        4, 5: begin
          cx = CB'(int'($urandom_range(0, 2000)) - 1000);
          cy = CB'(int'($urandom_range(0, 2000)) - 1000);
          cz = CB'(int'($urandom_range(0, 2000)) - 1000);
        end
        6: cz = 0;
        7: begin
          if ($urandom_range(0, 1)) cx = 0; else cy = 0;
        end
        8: begin
          m = $urandom_range(0, 5);
          cx = cx >>> (CB - 1 - m);
          cy = cy >>> (CB - 1 - m);
          cz = cz >>> (CB - 1 - m);
        end
        9: begin
          cx = cx ^ {1'b0, {(CB-1){1'b1}}} & {CB{cx[CB-1]}};
          cz = CB'(int'($urandom_range(0, 6)) - 3);
        end
        default: ;
      endcase
      send_point(cx, cy, cz);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (polar_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    coord_x_i   = '0;
    coord_y_i   = '0;
    coord_z_i   = '0;
    fill_atan_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1500);
    drain();
    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/c2p3_pkg.sv
hw/rtl/c2p3_cordic.sv
hw/rtl/c2p3_sqrt.sv
hw/rtl/cartesian_to_polar_3d_unit.sv
tb/tb.sv
